// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl result stage (mblp_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mblp_pkg.sv =====
// types, constants and helpers of the media block lace parser
`default_nettype none
package mblp_pkg;
    localparam int unsigned MAX_CODE_BYTES = 8;
    localparam int unsigned OFF_W          = 25;
    localparam logic [OFF_W-1:0] MAX_BLOCK_BYTES = 25'h100_0000;
    localparam logic [23:0] M24            = 24'hFF_FFFF;
    localparam int unsigned FIFO_DEPTH_DEF = 4;
    localparam int unsigned DIV_STEPS      = 25;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_FRAME   = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_TRUNC    = 3'd0;
    localparam logic [2:0] ERR_CODE     = 3'd1;
    localparam logic [2:0] ERR_LACE     = 3'd2;
    localparam logic [2:0] ERR_DIVIDE   = 3'd3;
    localparam logic [2:0] ERR_OVERRUN  = 3'd4;
    localparam logic [2:0] ERR_NO_DATA  = 3'd5;

    localparam logic [1:0] LACE_NONE  = 2'd0;
    localparam logic [1:0] LACE_XIPH  = 2'd1;
    localparam logic [1:0] LACE_FIXED = 2'd2;
    localparam logic [1:0] LACE_DELTA = 2'd3;

    // one result record; with div set, flen is the payload size and frep the count
    typedef struct packed {
        logic [1:0]  kind;
        logic        div;
        logic [55:0] track;
        logic [15:0] timecode;
        logic        invis;
        logic [1:0]  lace;
        logic [7:0]  fidx;
        logic [24:0] flen;
        logic [8:0]  frep;
        logic [23:0] poff;
        logic [2:0]  ecode;
        logic        last;
    } t_rec;

    // fresh record of one kind
    function automatic t_rec new_rec(input logic [1:0] kind);
        t_rec r;
        r      = '0;
        r.kind = kind;
        r.frep = 9'd1;
        return r;
    endfunction

    // length of a variable-length code from its first byte, 0 when bad
    function automatic logic [3:0] code_len(input logic [7:0] b);
        logic [3:0] len;
        len = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) len = 4'(8 - i);
        end
        return len;
    endfunction

    // bias of a signed delta code of the given length
    function automatic logic [55:0] delta_bias(input logic [3:0] l);
        logic [55:0] v;
        unique case (l)
            4'd1:    v = (56'd1 << 6)  - 56'd1;
            4'd2:    v = (56'd1 << 13) - 56'd1;
            4'd3:    v = (56'd1 << 20) - 56'd1;
            4'd4:    v = (56'd1 << 27) - 56'd1;
            4'd5:    v = (56'd1 << 34) - 56'd1;
            4'd6:    v = (56'd1 << 41) - 56'd1;
            4'd7:    v = (56'd1 << 48) - 56'd1;
            4'd8:    v = (56'd1 << 55) - 56'd1;
            default: v = 56'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/mblp_front.sv =====
// byte parser: header, lace sizes and block end, emitting result records
`default_nettype none
module mblp_front
    import mblp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_start,
    input  wire logic       i_end,
    output logic            o_push,
    output t_rec            o_rec,
    input  wire logic       i_full
);
    typedef enum logic [3:0] {
        PH_IDLE, PH_TRACK, PH_TIME_HI, PH_TIME_LO, PH_FLAGS,
        PH_COUNT, PH_SIZES, PH_PAYLOAD, PH_DRAIN
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [OFF_W-1:0] r_off, n_off;
    logic [55:0]  r_acc, n_acc;
    logic [2:0]   r_left, n_left;
    logic [3:0]   r_clen, n_clen;
    logic [1:0]   r_lace, n_lace;
    logic [8:0]   r_ftot, n_ftot;
    logic [8:0]   r_fdone, n_fdone;
    logic [23:0]  r_sum, n_sum;
    logic [23:0]  r_prev, n_prev;
    logic [23:0]  r_xiph, n_xiph;
    logic [23:0]  r_pbeg, n_pbeg;
    logic [55:0]  r_track, n_track;
    logic [15:0]  r_time, n_time;
    logic         r_invis, n_invis;
    t_rec [2:0]   r_slot, n_slot;
    logic [1:0]   r_npend, n_npend;

    logic accept;
    assign accept  = i_valid && o_ready;
    assign o_ready = (r_npend == 2'd0);
    assign o_push  = (r_npend != 2'd0) && !i_full;
    assign o_rec   = r_slot[0];

    // parse one byte
    always_comb begin
        logic [OFF_W-1:0] off, p;
        logic [3:0]  len;
        logic        vdone, vbad, have, perr;
        logic [23:0] slen;
        logic [24:0] xs;
        logic signed [57:0] dl;
        t_rec        rec;
        n_phase = r_phase; n_off = r_off; n_acc = r_acc; n_left = r_left;
        n_clen = r_clen; n_lace = r_lace; n_ftot = r_ftot; n_fdone = r_fdone;
        n_sum = r_sum; n_prev = r_prev; n_xiph = r_xiph; n_pbeg = r_pbeg;
        n_track = r_track; n_time = r_time; n_invis = r_invis;
        n_slot = r_slot; n_npend = r_npend;
        off = '0; p = '0; len = '0; vdone = 1'b0; vbad = 1'b0; have = 1'b0;
        perr = 1'b0; slen = '0; xs = '0; dl = '0; rec = new_rec(KIND_HEADER);
        // shift out a pushed record
        if (o_push) begin
            n_slot  = {t_rec'('0), r_slot[2:1]};
            n_npend = r_npend - 2'd1;
        end
        if (accept) begin
            n_slot  = '0;
            n_npend = 2'd0;
            if (i_start) begin
                n_phase = PH_TRACK; n_off = '0; n_acc = '0; n_left = '0;
                n_clen = '0; n_lace = '0; n_ftot = '0; n_fdone = '0; n_sum = '0;
                n_prev = '0; n_xiph = '0; n_pbeg = '0; n_track = '0; n_time = '0;
                n_invis = 1'b0;
            end
            if (n_phase == PH_IDLE) begin
                n_phase = PH_IDLE;
            end else if (n_phase == PH_DRAIN) begin
                if (i_end) n_phase = PH_IDLE;
            end else if (n_off >= MAX_BLOCK_BYTES) begin
                rec = new_rec(KIND_ERROR); rec.ecode = ERR_OVERRUN; rec.last = 1'b1;
                n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                n_phase = i_end ? PH_IDLE : PH_DRAIN;
            end else begin
                off   = n_off;
                n_off = off + 1'b1;
                // variable-length code step, shared by track and delta sizes
                if (n_phase == PH_TRACK || (n_phase == PH_SIZES && n_lace != LACE_XIPH)) begin
                    if (n_left == 3'd0) begin
                        len = code_len(i_byte);
                        if (len == 4'd0 || 32'(len) > MAX_CODE_BYTES) begin
                            vbad = 1'b1;
                        end else begin
                            n_clen = len;
                            n_acc  = 56'(i_byte & (8'hFF >> len));
                            n_left = 3'(len - 4'd1);
                            vdone  = (n_left == 3'd0);
                        end
                    end else begin
                        n_acc  = {n_acc[47:0], i_byte};
                        n_left = n_left - 3'd1;
                        vdone  = (n_left == 3'd0);
                    end
                end
                unique case (n_phase)
                    PH_TRACK: begin
                        if (vbad) perr = 1'b1;
                        else if (vdone) begin
                            n_track = n_acc; n_phase = PH_TIME_HI;
                        end
                    end
                    PH_TIME_HI: begin
                        n_time = {i_byte, 8'h00}; n_phase = PH_TIME_LO;
                    end
                    PH_TIME_LO: begin
                        n_time = {n_time[15:8], i_byte}; n_phase = PH_FLAGS;
                    end
                    PH_FLAGS: begin
                        n_invis = i_byte[3];
                        n_lace  = i_byte[2:1];
                        rec = new_rec(KIND_HEADER);
                        rec.track = n_track; rec.timecode = n_time;
                        rec.invis = n_invis; rec.lace = n_lace;
                        n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                        if (n_lace == LACE_NONE) begin
                            n_ftot = 9'd1;
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_phase = PH_COUNT;
                        end
                    end
                    PH_COUNT: begin
                        n_ftot = {1'b0, i_byte} + 9'd1;
                        n_fdone = '0; n_left = '0; n_xiph = '0;
                        if (n_lace == LACE_FIXED || n_ftot == 9'd1) n_phase = PH_PAYLOAD;
                        else n_phase = PH_SIZES;
                    end
                    PH_SIZES: begin
                        if (n_lace == LACE_XIPH) begin
                            xs = {1'b0, n_xiph} + {17'd0, i_byte};
                            if (xs > {1'b0, M24}) begin
                                rec = new_rec(KIND_ERROR); rec.ecode = ERR_LACE;
                                rec.last = 1'b1;
                                n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                                n_phase = PH_DRAIN;
                            end else if (i_byte != 8'hFF) begin
                                slen = xs[23:0]; n_xiph = '0; have = 1'b1;
                            end else begin
                                n_xiph = xs[23:0];
                            end
                        end else if (vbad) begin
                            perr = 1'b1;
                        end else if (vdone) begin
                            if (n_fdone == 9'd0) begin
                                if (n_acc > {32'd0, M24}) begin
                                    rec = new_rec(KIND_ERROR); rec.ecode = ERR_LACE;
                                    rec.last = 1'b1;
                                    n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                                    n_phase = PH_DRAIN;
                                end else begin
                                    n_prev = n_acc[23:0]; slen = n_prev; have = 1'b1;
                                end
                            end else begin
                                dl = $signed({34'd0, n_prev}) + $signed({2'd0, n_acc})
                                   - $signed({2'd0, delta_bias(n_clen)});
                                if (dl < 0 || dl > $signed({34'd0, M24})) begin
                                    rec = new_rec(KIND_ERROR); rec.ecode = ERR_LACE;
                                    rec.last = 1'b1;
                                    n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                                    n_phase = PH_DRAIN;
                                end else begin
                                    n_prev = dl[23:0]; slen = n_prev; have = 1'b1;
                                end
                            end
                        end
                    end
                    default: n_phase = n_phase;
                endcase
                // bad variable-length code
                if (perr) begin
                    rec = new_rec(KIND_ERROR); rec.ecode = ERR_CODE; rec.last = 1'b1;
                    n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                    n_phase = PH_DRAIN;
                end
                // record one lace size
                if (have) begin
                    if ({1'b0, n_sum} + {1'b0, slen} > {1'b0, M24}) begin
                        rec = new_rec(KIND_ERROR); rec.ecode = ERR_OVERRUN; rec.last = 1'b1;
                        n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_sum = n_sum + slen;
                        rec = new_rec(KIND_FRAME); rec.fidx = n_fdone[7:0];
                        rec.flen = {1'b0, slen};
                        n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                        n_fdone = n_fdone + 9'd1;
                        if ({1'b0, n_fdone} + 10'd1 >= {1'b0, n_ftot}) n_phase = PH_PAYLOAD;
                    end
                end
                // payload start marker
                if (n_phase == PH_PAYLOAD && r_phase != PH_PAYLOAD || 
                    n_phase == PH_PAYLOAD && i_start) begin
                    n_pbeg = 24'(off + 1'b1);
                    rec = new_rec(KIND_PAYLOAD); rec.poff = n_pbeg;
                    n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                end
                // block end
                if (i_end) begin
                    if (n_phase == PH_PAYLOAD) begin
                        p = off + 1'b1 - {1'b0, n_pbeg};
                        if (n_lace == LACE_FIXED) begin
                            rec = new_rec(KIND_FRAME); rec.div = 1'b1; rec.flen = p;
                            rec.frep = n_ftot; rec.last = 1'b1;
                        end else if (p == '0) begin
                            rec = new_rec(KIND_ERROR); rec.ecode = ERR_NO_DATA; rec.last = 1'b1;
                        end else if ({1'b0, n_sum} > p ||
                                     p - {1'b0, n_sum} > {1'b0, M24}) begin
                            rec = new_rec(KIND_ERROR); rec.ecode = ERR_OVERRUN; rec.last = 1'b1;
                        end else begin
                            rec = new_rec(KIND_FRAME); rec.fidx = n_fdone[7:0];
                            rec.flen = p - {1'b0, n_sum}; rec.last = 1'b1;
                        end
                        n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                    end else if (n_phase != PH_DRAIN) begin
                        rec = new_rec(KIND_ERROR); rec.ecode = ERR_TRUNC; rec.last = 1'b1;
                        n_slot[n_npend] = rec; n_npend = n_npend + 2'd1;
                    end
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_off <= '0; r_acc <= '0; r_left <= '0;
            r_clen <= '0; r_lace <= '0; r_ftot <= '0; r_fdone <= '0; r_sum <= '0;
            r_prev <= '0; r_xiph <= '0; r_pbeg <= '0; r_track <= '0; r_time <= '0;
            r_invis <= 1'b0; r_npend <= '0;
        end else begin
            r_phase <= n_phase; r_off <= n_off; r_acc <= n_acc; r_left <= n_left;
            r_clen <= n_clen; r_lace <= n_lace; r_ftot <= n_ftot; r_fdone <= n_fdone;
            r_sum <= n_sum; r_prev <= n_prev; r_xiph <= n_xiph; r_pbeg <= n_pbeg;
            r_track <= n_track; r_time <= n_time; r_invis <= n_invis;
            r_npend <= n_npend;
        end
        r_slot <= n_slot;
    end
endmodule
`default_nettype wire

// ===== rtl/mblp_fifo.sv =====
// short record queue between parser and result stage
`default_nettype none
module mblp_fifo
    import mblp_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_rec      i_rec,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_rec      o_rec
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_rec            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_rec;
    end
endmodule
`default_nettype wire

// ===== rtl/mblp_back.sv =====
// result stage: fixed-lacing divider and output register
`default_nettype none
`include "assert_macros.svh"
module mblp_back
    import mblp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_rec      i_rec,
    output logic      o_pop,
    output logic      o_valid,
    output t_rec      o_rec,
    input  wire logic i_ready
);
    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} t_state;

    t_state      r_state, n_state;
    logic        div_busy;
    logic [8:0]  r_rem, n_rem;
    logic [24:0] r_quo, n_quo;
    logic [8:0]  r_div, n_div;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_ovalid, n_ovalid;
    t_rec        r_out, n_out;
    logic        slot_free;

    assign slot_free = !r_ovalid || i_ready;
    assign o_valid   = r_ovalid;
    assign o_rec     = r_out;
    assign o_pop     = (r_state == ST_IDLE) && i_valid && slot_free;
    assign div_busy  = (r_state == ST_DIV);

    // next state, one restoring division step per cycle
    always_comb begin
        logic [9:0] sh;
        logic [9:0] diff;
        n_state = r_state; n_rem = r_rem; n_quo = r_quo; n_div = r_div;
        n_cnt = r_cnt; n_out = r_out;
        n_ovalid = r_ovalid && !i_ready;
        sh = {r_rem, r_quo[24]};
        diff = sh - {1'b0, r_div};
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    if (i_rec.div) begin
                        n_quo = i_rec.flen; n_div = i_rec.frep; n_rem = '0;
                        n_cnt = 5'(DIV_STEPS - 1); n_state = ST_DIV;
                    end else begin
                        n_out = i_rec; n_ovalid = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (sh >= {1'b0, r_div}) begin
                    n_rem = diff[8:0]; n_quo = {r_quo[23:0], 1'b1};
                end else begin
                    n_rem = sh[8:0];   n_quo = {r_quo[23:0], 1'b0};
                end
                if (r_cnt == '0) n_state = ST_EMIT;
                else n_cnt = r_cnt - 5'd1;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out = new_rec(KIND_FRAME); n_out.last = 1'b1;
                    if (r_rem != '0) begin
                        n_out.kind = KIND_ERROR; n_out.ecode = ERR_DIVIDE;
                    end else if (r_quo[24]) begin
                        n_out.kind = KIND_ERROR; n_out.ecode = ERR_OVERRUN;
                    end else begin
                        n_out.flen = r_quo; n_out.frep = r_div;
                    end
                    n_ovalid = 1'b1; n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ovalid <= 1'b0; r_cnt <= '0;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_quo <= n_quo; r_div <= n_div; r_out <= n_out;
    end

    `ASSERT_IMPLIES(a_no_pop_busy, i_clk, i_rst_n, div_busy, !o_pop)
    `ASSERT_IMPLIES(a_err_last, i_clk, i_rst_n, r_ovalid && r_out.kind == KIND_ERROR, r_out.last)
    `ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, div_busy && r_cnt != '0, div_busy)
endmodule
`default_nettype wire

// ===== rtl/media_block_lace_parser.sv =====
// Media block lace parser: takes one block byte per transaction (tuser marks the
// first byte, tlast the last) and emits header, frame size, payload start and
// error results. A byte that causes no result does not hold the input; a byte that
// causes results holds the input while the parser hands them to a short queue. The
// end of a fixed-laced block runs a bit-serial divider in the result stage, which
// the parser overlaps with further input while the queue has room.
`default_nettype none
module media_block_lace_parser
    import mblp_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,  // data_byte
    input  wire logic         s_axis_tuser,  // block_start
    input  wire logic         s_axis_tlast,  // block_end
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // track_number, timecode, invisible, lacing_mode, frame_index, frame_length,
    // frame_repeat, payload_offset, error_code, one zero pad bit
    output logic [143:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser,  // result_kind
    output logic              m_axis_tlast   // last_of_run
);
    logic push, full, pop, qvalid;
    t_rec front_rec, q_rec, out_rec;

    mblp_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (s_axis_tvalid), .o_ready (s_axis_tready),
        .i_byte (s_axis_tdata), .i_start (s_axis_tuser), .i_end (s_axis_tlast),
        .o_push (push), .o_rec (front_rec), .i_full (full)
    );

    mblp_fifo #(.DEPTH (FIFO_DEPTH)) u_fifo (
        .i_clk, .i_rst_n,
        .i_push (push), .i_rec (front_rec), .o_full (full),
        .i_pop (pop), .o_valid (qvalid), .o_rec (q_rec)
    );

    mblp_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (qvalid), .i_rec (q_rec), .o_pop (pop),
        .o_valid (m_axis_tvalid), .o_rec (out_rec), .i_ready (m_axis_tready)
    );

    // pack the result fields
    assign m_axis_tdata = {1'b0, out_rec.ecode, out_rec.poff, out_rec.frep,
                           out_rec.flen[23:0], out_rec.fidx, out_rec.lace,
                           out_rec.invis, out_rec.timecode, out_rec.track};
    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tlast = out_rec.last;
endmodule
`default_nettype wire

// ===== verif/media_block_lace_parser_tb.sv =====
// testbench for the media block lace parser: directed and random blocks checked against a predictor
`timescale 1ns / 1ps
module media_block_lace_parser_tb;
    import mblp_pkg::*;

    localparam int unsigned BLOCK_LIMIT = 25'h100_0000;

    // phases of the header and lace parse
    typedef enum logic [3:0] {
        P_IDLE, P_TRACK, P_TIME_HI, P_TIME_LO, P_FLAGS, P_COUNT, P_SIZES, P_PAYLOAD, P_DRAIN
    } t_phase;

    // one expected result
    typedef struct {
        logic [1:0]  kind;
        logic [55:0] track;
        logic [15:0] timecode;
        logic        invis;
        logic [1:0]  lace;
        logic [7:0]  fidx;
        logic [23:0] flen;
        logic [8:0]  frep;
        logic [23:0] poff;
        logic [2:0]  ecode;
        logic        last;
    } t_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;  // data_byte
    logic         s_axis_tuser;  // block_start
    logic         s_axis_tlast;  // block_end
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // track_number, timecode, invisible, lacing_mode, frame_index, frame_length,
    // frame_repeat, payload_offset, error_code, one zero pad bit
    logic [143:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;  // result_kind
    logic         m_axis_tlast;  // last_of_run

    media_block_lace_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_result     expected_results[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold_cycles;
    logic [7:0]  block_bytes[$];

    // parser state held by the predictor
    t_phase      ph;
    longint      boff;
    logic [55:0] acc;
    int          cleft;
    int          clen;
    logic [1:0]  lmode;
    int          ftot;
    int          fdone;
    longint      ssum;
    longint      prev_len;
    longint      xpart;
    longint      pbeg;
    logic [55:0] trk_held;
    logic [15:0] tc_held;
    logic        inv_held;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_result blank_result(input logic [1:0] kind);
        t_result r;
        r = '{kind: kind, track: '0, timecode: '0, invis: 1'b0, lace: '0, fidx: '0,
              flen: '0, frep: 9'd1, poff: '0, ecode: '0, last: 1'b0};
        return r;
    endfunction

    function automatic void clear_parser();
        ph = P_IDLE; boff = 0; acc = '0; cleft = 0; clen = 0; lmode = '0;
        ftot = 0; fdone = 0; ssum = 0; prev_len = 0; xpart = 0; pbeg = 0;
        trk_held = '0; tc_held = '0; inv_held = 1'b0;
    endfunction

    function automatic void push_error(input logic [2:0] code);
        t_result r;
        r = blank_result(KIND_ERROR);
        r.ecode = code;
        r.last  = 1'b1;
        expected_results = {expected_results, r};
        ph = P_DRAIN;
    endfunction

    function automatic void push_frame(input longint len, input logic last, input int rep);
        t_result r;
        r = blank_result(KIND_FRAME);
        r.fidx = fdone[7:0];
        r.flen = len[23:0];
        r.frep = rep[8:0];
        r.last = last;
        expected_results = {expected_results, r};
    endfunction

    function automatic void push_payload(input longint off);
        t_result r;
        pbeg = (off + 1) & M24;
        r = blank_result(KIND_PAYLOAD);
        r.poff = pbeg[23:0];
        expected_results = {expected_results, r};
        ph = P_PAYLOAD;
    endfunction

    // 1 when a code is complete, 0 while more bytes are due, -1 on a bad first byte
    function automatic int feed_code(input logic [7:0] b);
        int len;
        if (cleft == 0) begin
            if (b == 8'd0) return -1;
            len = 1;
            while (b[8 - len] == 1'b0) len++;
            clen  = len;
            acc   = 56'(b & (8'hFF >> len));
            cleft = len - 1;
            return (cleft == 0) ? 1 : 0;
        end
        acc = {acc[47:0], b};
        cleft--;
        return (cleft == 0) ? 1 : 0;
    endfunction

    function automatic void record_size(input longint len, input longint off);
        if (ssum + len > M24) begin
            push_error(ERR_OVERRUN);
            return;
        end
        ssum += len;
        push_frame(len, 1'b0, 1);
        fdone++;
        if (fdone + 1 >= ftot) push_payload(off);
    endfunction

    // expected results of one accepted block byte
    function automatic void predict_parse(input logic [7:0] b, input logic st, input logic en);
        longint  off;
        longint  p;
        longint  len;
        longint  bias;
        int      v;
        t_result r;
        if (st) begin
            clear_parser();
            ph = P_TRACK;
        end
        if (ph == P_IDLE) return;
        if (ph == P_DRAIN) begin
            if (en) ph = P_IDLE;
            return;
        end
        if (boff >= BLOCK_LIMIT) begin
            push_error(ERR_OVERRUN);
            if (en) ph = P_IDLE;
            return;
        end
        off = boff;
        boff++;
        case (ph)
            P_TRACK: begin
                v = feed_code(b);
                if (v < 0) push_error(ERR_CODE);
                else if (v > 0) begin
                    trk_held = acc;
                    ph = P_TIME_HI;
                end
            end
            P_TIME_HI: begin
                tc_held[15:8] = b;
                ph = P_TIME_LO;
            end
            P_TIME_LO: begin
                tc_held[7:0] = b;
                ph = P_FLAGS;
            end
            P_FLAGS: begin
                inv_held = b[3];
                lmode    = b[2:1];
                r = blank_result(KIND_HEADER);
                r.track    = trk_held;
                r.timecode = tc_held;
                r.invis    = inv_held;
                r.lace     = lmode;
                expected_results = {expected_results, r};
                if (lmode == LACE_NONE) begin
                    ftot = 1;
                    push_payload(off);
                end else ph = P_COUNT;
            end
            P_COUNT: begin
                ftot  = int'(b) + 1;
                fdone = 0;
                cleft = 0;
                xpart = 0;
                if (lmode == LACE_FIXED || ftot == 1) push_payload(off);
                else ph = P_SIZES;
            end
            P_SIZES: begin
                if (lmode == LACE_XIPH) begin
                    xpart += b;
                    if (xpart > M24) push_error(ERR_LACE);
                    else if (b < 8'd255) begin
                        len   = xpart;
                        xpart = 0;
                        record_size(len, off);
                    end
                end else begin
                    v = feed_code(b);
                    if (v < 0) push_error(ERR_CODE);
                    else if (v > 0) begin
                        if (fdone == 0) begin
                            if (acc > M24) push_error(ERR_LACE);
                            else prev_len = longint'(acc);
                        end else begin
                            bias = (longint'(1) << (7 * clen - 1)) - 1;
                            len  = prev_len + (longint'(acc) - bias);
                            if (len < 0 || len > M24) push_error(ERR_LACE);
                            else prev_len = len;
                        end
                        if (ph == P_SIZES) record_size(prev_len, off);
                    end
                end
            end
            default: ;
        endcase
        if (en) begin
            if (ph == P_PAYLOAD) begin
                p = off + 1 - pbeg;
                if (lmode == LACE_FIXED) begin
                    if (p % ftot != 0) push_error(ERR_DIVIDE);
                    else if (p / ftot > M24) push_error(ERR_OVERRUN);
                    else begin
                        fdone = 0;
                        push_frame(p / ftot, 1'b1, ftot);
                    end
                end else if (p == 0) push_error(ERR_NO_DATA);
                else if (ssum > p || p - ssum > M24) push_error(ERR_OVERRUN);
                else push_frame(p - ssum, 1'b1, 1);
            end else if (ph != P_DRAIN) begin
                push_error(ERR_TRUNC);
            end
            ph = P_IDLE;
        end
    endfunction

    // sends one byte and waits for its transaction
    task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        s_axis_tlast  <= en;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_parse(b, st, en);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_block();
        foreach (block_bytes[i])
            send_byte(block_bytes[i], i == 0, i == block_bytes.size() - 1);
        block_bytes.delete();
    endtask

    task automatic wait_drained();
        stop_sending();
        wait (expected_results.size() == 0);
        repeat (60) @(negedge i_clk);
    endtask

    // variable-length code of the given length holding val
    function automatic void put_code(input longint val, input int len);
        logic [7:0] b;
        for (int i = len - 1; i >= 0; i--) begin
            b = 8'(val >> (8 * i));
            if (i == len - 1) b |= 8'h80 >> (len - 1);
            block_bytes = {block_bytes, b};
        end
    endfunction

    function automatic void put_header(input int lace);
        int     len;
        longint val;
        len = ($urandom_range(3) == 0) ? $urandom_range(8, 1) : 1;
        val = {$urandom(), $urandom()} & ((longint'(1) << (7 * len)) - 1);
        put_code(val, len);
        block_bytes = {block_bytes, 8'($urandom())};
        block_bytes = {block_bytes, 8'($urandom())};
        block_bytes = {block_bytes, (8'($urandom()) & 8'hF9) | 8'(lace << 1)};
    endfunction

    function automatic void put_random(input int n);
        repeat (n) block_bytes = {block_bytes, 8'($urandom())};
    endfunction

    // well-formed block with random content, sometimes bent out of shape
    function automatic void build_block(input int lace);
        int     nsz;
        int     sz;
        int     sum;
        int     prev;
        int     len;
        longint val;
        put_header(lace);
        sum = 0;
        if (lace == LACE_FIXED) begin
            nsz = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(7);
            block_bytes = {block_bytes, 8'(nsz)};
            sz = (nsz > 20) ? $urandom_range(1) : $urandom_range(6);
            put_random((nsz + 1) * sz + (($urandom_range(5) == 0) ? 1 : 0));
            return;
        end
        if (lace != LACE_NONE) begin
            nsz = $urandom_range(5);
            block_bytes = {block_bytes, 8'(nsz)};
            prev = 0;
            for (int i = 0; i < nsz; i++) begin
                sz = ($urandom_range(7) == 0) ? $urandom_range(600) : $urandom_range(12);
                if (lace == LACE_XIPH) begin
                    repeat (sz / 255) block_bytes = {block_bytes, 8'd255};
                    block_bytes = {block_bytes, 8'(sz % 255)};
                end else if (i == 0) begin
                    put_code(sz, $urandom_range(3, 1));
                end else begin
                    if ($urandom_range(9) == 0) sz = -$urandom_range(50, 1);
                    len = 1;
                    while (longint'(sz - prev) + (longint'(1) << (7 * len - 1)) - 1
                           >= (longint'(1) << (7 * len)) - 1)
                        len++;
                    len = len + $urandom_range(1);
                    val = longint'(sz - prev) + (longint'(1) << (7 * len - 1)) - 1;
                    put_code(val, len);
                end
                prev = sz;
                sum += (sz > 0) ? sz : 0;
            end
        end
        sz = sum + $urandom_range(12);
        if ($urandom_range(7) == 0) sz = $urandom_range(sum);
        if (sz > 60) sz = 60 + $urandom_range(8);
        put_random(sz);
    endfunction

    // compare one field of a result
    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result_kind: expected none, got 0x%0h", m_axis_tuser);
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("result_kind", e.kind, m_axis_tuser);
                check_field("track_number", e.track, m_axis_tdata[55:0]);
                check_field("timecode", e.timecode, m_axis_tdata[71:56]);
                check_field("invisible", e.invis, m_axis_tdata[72]);
                check_field("lacing_mode", e.lace, m_axis_tdata[74:73]);
                check_field("frame_index", e.fidx, m_axis_tdata[82:75]);
                check_field("frame_length", e.flen, m_axis_tdata[106:83]);
                check_field("frame_repeat", e.frep, m_axis_tdata[115:107]);
                check_field("payload_offset", e.poff, m_axis_tdata[139:116]);
                check_field("error_code", e.ecode, m_axis_tdata[142:140]);
                check_field("last_of_run", e.last, m_axis_tlast);
            end
        end
    end

    // receiver: random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            m_axis_tready    <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // bytes outside any block
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // no lacing, one payload byte, widest track code of all ones
        block_bytes = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        8'h7F, 8'hFF, 8'hF9, 8'h42};
        send_block();
        // empty payload without lacing
        block_bytes = '{8'h81, 8'h80, 8'h00, 8'h00};
        send_block();
        // bad track code
        block_bytes = '{8'h00, 8'h12, 8'h34};
        send_block();
        // early end in the timecode
        block_bytes = '{8'h82, 8'h00};
        send_block();
        // start inside a block, then xiph with a zero size and a 255 size
        send_byte(8'h81, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        block_bytes = '{8'h83, 8'h00, 8'h01, 8'h0A, 8'h02, 8'h00, 8'hFF, 8'h00};
        put_random(255 + 3);
        send_block();
        // fixed lacing with empty payload, then one not divisible
        block_bytes = '{8'h81, 8'h00, 8'h00, 8'h04, 8'hFF};
        send_block();
        block_bytes = '{8'h81, 8'h00, 8'h00, 8'h04, 8'h01, 8'h11, 8'h22, 8'h33};
        send_block();
        // delta lacing with a negative delta below zero
        block_bytes = '{8'h81, 8'h00, 8'h00, 8'h06, 8'h02, 8'h82, 8'h81, 8'h00};
        send_block();
        // delta lacing with a good negative delta and a lace sum past the payload
        block_bytes = '{8'h81, 8'h00, 8'h00, 8'h06, 8'h02, 8'h85, 8'hBD, 8'h01};
        send_block();
        // bytes after an error block, before a start
        send_byte(8'h55, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                put_random($urandom_range(6, 1));
            end else begin
                build_block($urandom_range(3));
                if ($urandom_range(9) == 0)
                    block_bytes = block_bytes[0:$urandom_range(block_bytes.size() - 1)];
            end
            if ($urandom_range(19) == 0) send_byte(8'($urandom()), 1'b0, 1'($urandom()));
            sent += block_bytes.size();
            send_block();
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        recv_hold_cycles = 400;
        repeat (2) begin
            build_block(LACE_NONE);
            send_block();
            build_block(LACE_FIXED);
            send_block();
        end
        wait_drained();
    endtask

    initial begin
        fail_count       = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        recv_hold_cycles = 0;
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = 1'b0;
        s_axis_tlast     = 1'b0;
        m_axis_tready    = 1'b0;
        clear_parser();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        send_idle_pct = 22;
        recv_idle_pct = 71;
        test_random(30);
        send_idle_pct = 71;
        recv_idle_pct = 22;
        test_random(30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(30);
        test_backpressure();

        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial begin
        #30ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/mblp_pkg.sv
rtl/mblp_front.sv
rtl/mblp_fifo.sv
rtl/mblp_back.sv
rtl/media_block_lace_parser.sv
verif/media_block_lace_parser_tb.sv
